[rtl/core/mvrw_pkg.sv]
// mvrw_pkg: shared types, field widths, opcodes and corner arithmetic for
// the mesh vertex ring walk block.
// Depends on nothing; used by every other file of the block.
package mvrw_pkg;

  localparam int MAX_FACES_DEF    = 1024;
  localparam int MAX_VERTICES_DEF = 512;

  localparam int OPC_W    = 2;
  localparam int CORNER_W = 12;
  localparam int VERTEX_W = 9;
  localparam int LEN_W    = 10;
  localparam int VTALLY_W = 10;
  localparam int TTALLY_W = 11;
  localparam int FCNT_W   = 11;
  localparam int VCNT_W   = 10;

  localparam int FACES_RST = 1024;
  localparam int VERTS_RST = 512;
  localparam int FACES_MIN = 1;
  localparam int VERTS_MIN = 3;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [OPC_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OPC_W-1:0] OP_WALK = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ = 2'd2;

  localparam logic REG_FACES = 1'b0;
  localparam logic REG_VERTS = 1'b1;

  typedef struct packed {
    logic [OPC_W-1:0]    opcode;
    logic [CORNER_W-1:0] index;
    logic [VERTEX_W-1:0] corner_vertex;
    logic [CORNER_W-1:0] corner_opposite;
  } item_t;

  typedef struct packed {
    logic [CORNER_W-1:0] ring_corner;
    logic [VERTEX_W-1:0] ring_vertex;
    logic [LEN_W-1:0]    ring_length;
    logic [VTALLY_W-1:0] marked_vertices;
    logic [TTALLY_W-1:0] marked_triangles;
    logic                all_covered;
    logic                status;
  } result_t;

  typedef struct packed {
    logic [FCNT_W-1:0] face_count;
    logic [VCNT_W-1:0] vertex_count;
  } cfg_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [CORNER_W-1:0] opp;
  } corner_ent_t;

  typedef struct packed {
    logic [CORNER_W-2:0] q;
    logic [1:0]          r;
  } div3_t;

  // c/3 as (c * 2731) >> 13, exact for every 12-bit c
  function automatic div3_t div3(input logic [CORNER_W-1:0] c);
    logic [2*CORNER_W-1:0] prod;
    logic [CORNER_W-1:0]   base;
    div3_t                 d;
    prod = (2*CORNER_W)'(c) * 24'd2731;
    d.q  = prod[2*CORNER_W-1:13];
    base = CORNER_W'({1'b0, d.q} + {d.q, 1'b0});
    d.r  = 2'(c - base);
    return d;
  endfunction

  function automatic logic [CORNER_W-1:0] tri_base(input div3_t d);
    return CORNER_W'({1'b0, d.q} + {d.q, 1'b0});
  endfunction

  function automatic logic [CORNER_W-1:0] pred_corner(input logic [CORNER_W-1:0] c);
    div3_t      d;
    logic [1:0] off;
    d   = div3(c);
    off = (d.r == 2'd0) ? 2'd2 : 2'(d.r - 2'd1);
    return tri_base(d) + CORNER_W'(off);
  endfunction

  function automatic logic [CORNER_W-1:0] succ_corner(input logic [CORNER_W-1:0] c);
    div3_t      d;
    logic [1:0] off;
    d   = div3(c);
    off = (d.r == 2'd2) ? 2'd0 : 2'(d.r + 2'd1);
    return tri_base(d) + CORNER_W'(off);
  endfunction

endpackage

[rtl/core/mvrw_if.sv]
// mvrw_in_if / mvrw_out_if: valid/ready request and result channels of the block.
// Depends on mvrw_pkg for field widths.
interface mvrw_in_if;
  logic                          valid;
  logic                          ready;
  logic [mvrw_pkg::OPC_W-1:0]    opcode;
  logic [mvrw_pkg::CORNER_W-1:0] index;
  logic [mvrw_pkg::VERTEX_W-1:0] corner_vertex;
  logic [mvrw_pkg::CORNER_W-1:0] corner_opposite;

  modport source(output valid, opcode, index, corner_vertex, corner_opposite, input ready);
  modport sink(input valid, opcode, index, corner_vertex, corner_opposite, output ready);
endinterface

interface mvrw_out_if;
  logic                          valid;
  logic                          ready;
  logic [mvrw_pkg::CORNER_W-1:0] ring_corner;
  logic [mvrw_pkg::VERTEX_W-1:0] ring_vertex;
  logic [mvrw_pkg::LEN_W-1:0]    ring_length;
  logic [mvrw_pkg::VTALLY_W-1:0] marked_vertices;
  logic [mvrw_pkg::TTALLY_W-1:0] marked_triangles;
  logic                          all_covered;
  logic                          status;

  modport source(output valid, ring_corner, ring_vertex, ring_length, marked_vertices,
                 marked_triangles, all_covered, status, input ready);
  modport sink(input valid, ring_corner, ring_vertex, ring_length, marked_vertices,
               marked_triangles, all_covered, status, output ready);
endinterface

[rtl/core/mvrw_cfg.sv]
// mvrw_cfg: APB register file holding face_count and vertex_count.
// Depends on mvrw_pkg.
module mvrw_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mvrw_pkg::ADDR_W-1:0]   paddr,
  input  logic [mvrw_pkg::DATA_W-1:0]   pwdata,
  output logic [mvrw_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mvrw_pkg::cfg_t                cfg
);

  logic [mvrw_pkg::FCNT_W-1:0] face_count_r, face_count_nxt;
  logic [mvrw_pkg::VCNT_W-1:0] vertex_count_r, vertex_count_nxt;
  logic                        wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    face_count_nxt   = face_count_r;
    vertex_count_nxt = vertex_count_r;
    if (wr_en) begin
      if (paddr[2] == mvrw_pkg::REG_VERTS) begin
        vertex_count_nxt = pwdata[mvrw_pkg::VCNT_W-1:0];
      end else begin
        face_count_nxt = pwdata[mvrw_pkg::FCNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_count_r   <= mvrw_pkg::FCNT_W'(mvrw_pkg::FACES_RST);
      vertex_count_r <= mvrw_pkg::VCNT_W'(mvrw_pkg::VERTS_RST);
    end else begin
      face_count_r   <= face_count_nxt;
      vertex_count_r <= vertex_count_nxt;
    end
  end

  assign prdata = (paddr[2] == mvrw_pkg::REG_VERTS) ?
                  mvrw_pkg::DATA_W'(vertex_count_r) : mvrw_pkg::DATA_W'(face_count_r);

  assign cfg.face_count   = face_count_r;
  assign cfg.vertex_count = vertex_count_r;

endmodule

[rtl/core/mvrw_engine.sv]
// mvrw_engine: corner table, mark, open stack and ring memories with the
// sequencer that loads, walks and reads them. Depends on mvrw_pkg.
module mvrw_engine #(
  parameter int MAX_FACES    = mvrw_pkg::MAX_FACES_DEF,
  parameter int MAX_VERTICES = mvrw_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mvrw_pkg::cfg_t    cfg,
  input  logic              item_valid,
  input  mvrw_pkg::item_t   item,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output mvrw_pkg::result_t res
);

  localparam int CORNER_DEPTH = 3 * MAX_FACES;
  localparam int RING_DEPTH   = MAX_VERTICES + 2;
  localparam int WALK_LIMIT   = 48 * MAX_FACES;
  localparam int CLR_DEPTH    = (MAX_FACES > MAX_VERTICES) ? MAX_FACES : MAX_VERTICES;
  localparam int CAW = $clog2(CORNER_DEPTH);
  localparam int VAW = $clog2(MAX_VERTICES);
  localparam int TAW = $clog2(MAX_FACES);
  localparam int RAW = $clog2(RING_DEPTH);
  localparam int NFW = $clog2(MAX_FACES + 1);
  localparam int NVW = $clog2(MAX_VERTICES + 1);
  localparam int NCW = $clog2(CORNER_DEPTH + 1);
  localparam int RCW = $clog2(MAX_VERTICES + 3);
  localparam int SPW = $clog2(WALK_LIMIT + 1);
  localparam int CLW = $clog2(CLR_DEPTH);
  localparam int CW  = mvrw_pkg::CORNER_W;
  localparam int VW  = mvrw_pkg::VERTEX_W;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_READ1 = 5'd1;
  localparam logic [4:0] S_READ2 = 5'd2;
  localparam logic [4:0] S_CLEAR = 5'd3;
  localparam logic [4:0] S_ST0   = 5'd4;
  localparam logic [4:0] S_ST1   = 5'd5;
  localparam logic [4:0] S_ST2   = 5'd6;
  localparam logic [4:0] S_ST3   = 5'd7;
  localparam logic [4:0] S_ST4   = 5'd8;
  localparam logic [4:0] S_A     = 5'd9;
  localparam logic [4:0] S_B     = 5'd10;
  localparam logic [4:0] S_C     = 5'd11;
  localparam logic [4:0] S_D     = 5'd12;
  localparam logic [4:0] S_E     = 5'd13;
  localparam logic [4:0] S_F     = 5'd14;
  localparam logic [4:0] S_CL1   = 5'd15;
  localparam logic [4:0] S_CL2   = 5'd16;
  localparam logic [4:0] S_FIN   = 5'd17;
  localparam logic [4:0] S_DONE  = 5'd18;

  // memories
  mvrw_pkg::corner_ent_t cmem [CORNER_DEPTH];
  logic                  vmem [MAX_VERTICES];
  logic                  tmem [MAX_FACES];
  logic [CW-1:0]         smem [MAX_VERTICES];
  logic [CW-1:0]         rmem [RING_DEPTH];

  logic                  cm_we;
  logic [CAW-1:0]        cm_waddr, cm_raddr;
  mvrw_pkg::corner_ent_t cm_wdata, cm_rdata;
  logic                  vm_we, vm_wdata, vm_rdata;
  logic [VAW-1:0]        vm_waddr, vm_raddr;
  logic                  tm_we, tm_wdata, tm_rdata;
  logic [TAW-1:0]        tm_waddr, tm_raddr;
  logic                  st_we;
  logic [VAW-1:0]        st_waddr, st_raddr;
  logic [CW-1:0]         st_wdata, st_rdata;
  logic                  rg_we;
  logic [RAW-1:0]        rg_waddr, rg_raddr;
  logic [CW-1:0]         rg_wdata, rg_rdata;

  logic [4:0]    state_r, state_nxt;
  logic [CW-1:0] start_r, start_nxt, end_r, end_nxt, p_r, p_nxt, n_r, n_nxt;
  logic [CW-1:0] corner_r, corner_nxt, o_r, o_nxt, src_r, src_nxt, pc_r, pc_nxt;
  logic [VW-1:0] vp_r, vp_nxt, vn_r, vn_nxt, v_r, v_nxt;
  logic [TAW-1:0] t_r, t_nxt;
  logic          popped_r, popped_nxt, bad_r, bad_nxt;
  logic [SPW-1:0] steps_r, steps_nxt;
  logic [CLW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [NVW-1:0] top_r, top_nxt;
  logic [RCW-1:0] ring_count_r, ring_count_nxt;
  logic [NVW-1:0] vtally_r, vtally_nxt;
  logic [NFW-1:0] ttally_r, ttally_nxt;
  logic          covered_r, covered_nxt;
  logic [CW-1:0] res_rc_r, res_rc_nxt;
  logic [VW-1:0] res_rv_r, res_rv_nxt;
  logic          res_status_r, res_status_nxt;

  logic [NFW-1:0] nf;
  logic [NVW-1:0] nv;
  logic [NCW-1:0] nc;
  mvrw_pkg::div3_t dq;
  logic           item_take;

  // clamped configuration
  always_comb begin
    if (cfg.face_count < mvrw_pkg::FACES_MIN) begin
      nf = NFW'(mvrw_pkg::FACES_MIN);
    end else if (cfg.face_count > MAX_FACES) begin
      nf = NFW'(MAX_FACES);
    end else begin
      nf = NFW'(cfg.face_count);
    end
    if (cfg.vertex_count < mvrw_pkg::VERTS_MIN) begin
      nv = NVW'(mvrw_pkg::VERTS_MIN);
    end else if (cfg.vertex_count > MAX_VERTICES) begin
      nv = NVW'(MAX_VERTICES);
    end else begin
      nv = NVW'(cfg.vertex_count);
    end
  end

  assign nc        = (NCW'(nf) << 1) + NCW'(nf);
  assign dq        = mvrw_pkg::div3(corner_r);
  assign idle      = (state_r == S_IDLE);
  assign item_take = item_valid && idle;
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt      = state_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    p_nxt          = p_r;
    n_nxt          = n_r;
    corner_nxt     = corner_r;
    o_nxt          = o_r;
    src_nxt        = src_r;
    pc_nxt         = pc_r;
    vp_nxt         = vp_r;
    vn_nxt         = vn_r;
    v_nxt          = v_r;
    t_nxt          = t_r;
    popped_nxt     = popped_r;
    bad_nxt        = bad_r;
    steps_nxt      = steps_r;
    clr_cnt_nxt    = clr_cnt_r;
    top_nxt        = top_r;
    ring_count_nxt = ring_count_r;
    vtally_nxt     = vtally_r;
    ttally_nxt     = ttally_r;
    covered_nxt    = covered_r;
    res_rc_nxt     = res_rc_r;
    res_rv_nxt     = res_rv_r;
    res_status_nxt = res_status_r;
    cm_we = 1'b0; cm_waddr = '0; cm_wdata = '0; cm_raddr = '0;
    vm_we = 1'b0; vm_waddr = '0; vm_wdata = 1'b0; vm_raddr = '0;
    tm_we = 1'b0; tm_waddr = '0; tm_wdata = 1'b0; tm_raddr = '0;
    st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
    rg_we = 1'b0; rg_waddr = '0; rg_wdata = '0; rg_raddr = '0;

    case (state_r)
      S_IDLE: begin
        if (item_take) begin
          res_rc_nxt     = '0;
          res_rv_nxt     = '0;
          res_status_nxt = 1'b0;
          case (item.opcode)
            mvrw_pkg::OP_LOAD: begin
              if (item.index < nc) begin
                cm_we    = 1'b1;
                cm_waddr = CAW'(item.index);
                cm_wdata = '{vertex: item.corner_vertex, opp: item.corner_opposite};
              end
              state_nxt = S_DONE;
            end
            mvrw_pkg::OP_WALK: begin
              start_nxt      = item.index;
              clr_cnt_nxt    = '0;
              top_nxt        = '0;
              ring_count_nxt = '0;
              vtally_nxt     = '0;
              ttally_nxt     = '0;
              state_nxt      = S_CLEAR;
            end
            mvrw_pkg::OP_READ: begin
              if (item.index < ring_count_r) begin
                rg_raddr  = RAW'(item.index);
                state_nxt = S_READ1;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_READ1: begin
        res_rc_nxt = rg_rdata;
        cm_raddr   = CAW'(rg_rdata);
        state_nxt  = S_READ2;
      end
      S_READ2: begin
        if (res_rc_r < CORNER_DEPTH) begin
          res_rv_nxt = cm_rdata.vertex;
        end
        state_nxt = S_DONE;
      end
      S_CLEAR: begin
        if (clr_cnt_r < MAX_VERTICES) begin
          vm_we    = 1'b1;
          vm_waddr = VAW'(clr_cnt_r);
        end
        if (clr_cnt_r < MAX_FACES) begin
          tm_we    = 1'b1;
          tm_waddr = TAW'(clr_cnt_r);
        end
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLW'(CLR_DEPTH - 1)) begin
          state_nxt = S_ST0;
        end
      end
      S_ST0: begin
        if (start_r >= nc) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          cm_raddr  = CAW'(start_r);
          p_nxt     = mvrw_pkg::pred_corner(start_r);
          n_nxt     = mvrw_pkg::succ_corner(start_r);
          state_nxt = S_ST1;
        end
      end
      S_ST1: begin
        end_nxt   = cm_rdata.opp;
        cm_raddr  = CAW'(p_r);
        state_nxt = S_ST2;
      end
      S_ST2: begin
        vp_nxt    = cm_rdata.vertex;
        cm_raddr  = CAW'(n_r);
        state_nxt = S_ST3;
      end
      S_ST3: begin
        if (vp_r >= nv || cm_rdata.vertex >= nv) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          vn_nxt    = cm_rdata.vertex;
          vm_we     = 1'b1;
          vm_waddr  = VAW'(vp_r);
          vm_wdata  = 1'b1;
          st_we     = 1'b1;
          st_wdata  = start_r;
          rg_we     = 1'b1;
          rg_wdata  = p_r;
          state_nxt = S_ST4;
        end
      end
      S_ST4: begin
        vm_we          = 1'b1;
        vm_waddr       = VAW'(vn_r);
        vm_wdata       = 1'b1;
        rg_we          = 1'b1;
        rg_waddr       = RAW'(1);
        rg_wdata       = n_r;
        top_nxt        = NVW'(1);
        ring_count_nxt = RCW'(2);
        vtally_nxt     = NVW'(2);
        corner_nxt     = start_r;
        steps_nxt      = '0;
        state_nxt      = S_A;
      end
      S_A: begin
        if (steps_r >= WALK_LIMIT) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          steps_nxt = steps_r + 1'b1;
          cm_raddr  = CAW'(corner_r);
          t_nxt     = TAW'(dq.q);
          state_nxt = S_B;
        end
      end
      S_B: begin
        if (cm_rdata.vertex >= nv) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          v_nxt     = cm_rdata.vertex;
          o_nxt     = cm_rdata.opp;
          vm_raddr  = VAW'(cm_rdata.vertex);
          tm_raddr  = t_r;
          state_nxt = S_C;
        end
      end
      S_C: begin
        if (!vm_rdata) begin
          if (top_r >= MAX_VERTICES) begin
            res_status_nxt = 1'b1;
            state_nxt      = S_FIN;
          end else begin
            vm_we      = 1'b1;
            vm_waddr   = VAW'(v_r);
            vm_wdata   = 1'b1;
            tm_we      = 1'b1;
            tm_waddr   = t_r;
            tm_wdata   = 1'b1;
            vtally_nxt = vtally_r + 1'b1;
            ttally_nxt = ttally_r + 1'b1;
            st_we      = 1'b1;
            st_waddr   = VAW'(top_r);
            st_wdata   = corner_r;
            top_nxt    = top_r + 1'b1;
            src_nxt    = corner_r;
            popped_nxt = 1'b0;
            bad_nxt    = 1'b0;
            state_nxt  = S_D;
          end
        end else if (!tm_rdata) begin
          if (top_r == '0 || ring_count_r >= RING_DEPTH) begin
            res_status_nxt = 1'b1;
            state_nxt      = S_FIN;
          end else begin
            // pop now, ring write once the stack data is back
            st_raddr   = VAW'(top_r - 1'b1);
            top_nxt    = top_r - 1'b1;
            popped_nxt = 1'b1;
            src_nxt    = o_r;
            bad_nxt    = (o_r >= nc);
            state_nxt  = S_D;
          end
        end else begin
          src_nxt    = corner_r;
          popped_nxt = 1'b0;
          bad_nxt    = 1'b0;
          state_nxt  = S_D;
        end
      end
      S_D: begin
        if (popped_r) begin
          rg_we          = 1'b1;
          rg_waddr       = RAW'(ring_count_r);
          rg_wdata       = st_rdata;
          ring_count_nxt = ring_count_r + 1'b1;
        end
        if (bad_r) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_FIN;
        end else begin
          pc_nxt    = mvrw_pkg::pred_corner(src_r);
          state_nxt = S_E;
        end
      end
      S_E: begin
        cm_raddr  = CAW'(pc_r);
        state_nxt = S_F;
      end
      S_F: begin
        if (cm_rdata.opp >= nc) begin
          res_status_nxt = 1'b1;
          state_nxt      = S_FIN;
        end else if (cm_rdata.opp == end_r) begin
          state_nxt = S_CL1;
        end else begin
          corner_nxt = cm_rdata.opp;
          state_nxt  = S_A;
        end
      end
      S_CL1: begin
        rg_raddr  = '0;
        state_nxt = S_CL2;
      end
      S_CL2: begin
        rg_we     = 1'b1;
        rg_waddr  = RAW'(ring_count_r - 1'b1);
        rg_wdata  = rg_rdata;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        covered_nxt = (ring_count_r != '0) && (ring_count_r == ({1'b0, nv} + 1'b1));
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cmem[cm_waddr] <= cm_wdata;
    end
    cm_rdata <= cmem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (vm_we) begin
      vmem[vm_waddr] <= vm_wdata;
    end
    vm_rdata <= vmem[vm_raddr];
  end

  always_ff @(posedge clk) begin
    if (tm_we) begin
      tmem[tm_waddr] <= tm_wdata;
    end
    tm_rdata <= tmem[tm_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      smem[st_waddr] <= st_wdata;
    end
    st_rdata <= smem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (rg_we) begin
      rmem[rg_waddr] <= rg_wdata;
    end
    rg_rdata <= rmem[rg_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      top_r        <= '0;
      ring_count_r <= '0;
      vtally_r     <= '0;
      ttally_r     <= '0;
      covered_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      top_r        <= top_nxt;
      ring_count_r <= ring_count_nxt;
      vtally_r     <= vtally_nxt;
      ttally_r     <= ttally_nxt;
      covered_r    <= covered_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    p_r          <= p_nxt;
    n_r          <= n_nxt;
    corner_r     <= corner_nxt;
    o_r          <= o_nxt;
    src_r        <= src_nxt;
    pc_r         <= pc_nxt;
    vp_r         <= vp_nxt;
    vn_r         <= vn_nxt;
    v_r          <= v_nxt;
    t_r          <= t_nxt;
    popped_r     <= popped_nxt;
    bad_r        <= bad_nxt;
    steps_r      <= steps_nxt;
    clr_cnt_r    <= clr_cnt_nxt;
    res_rc_r     <= res_rc_nxt;
    res_rv_r     <= res_rv_nxt;
    res_status_r <= res_status_nxt;
  end

  assign res.ring_corner      = res_rc_r;
  assign res.ring_vertex      = res_rv_r;
  assign res.ring_length      = mvrw_pkg::LEN_W'(ring_count_r);
  assign res.marked_vertices  = mvrw_pkg::VTALLY_W'(vtally_r);
  assign res.marked_triangles = mvrw_pkg::TTALLY_W'(ttally_r);
  assign res.all_covered      = covered_r;
  assign res.status           = res_status_r;

  // a finished result holds until taken
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !res_ready) |=> (state_r == S_DONE))
    else $error("result dropped before it was taken");

  // walk init leaves two ring entries and one stack entry
  a_init_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ST4) |=> (ring_count_r == RCW'(2) && top_r == NVW'(1)))
    else $error("walk init counts wrong");

  // every push marks a vertex and a triangle together
  a_tally: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A) |-> ({1'b0, vtally_r} == {1'b0, ttally_r} + 2'd2))
    else $error("vertex and triangle tallies out of step");

  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_count_r <= RING_DEPTH) && (top_r <= MAX_VERTICES))
    else $error("ring or stack past its depth");

endmodule

[rtl/core/mesh_vertex_ring_walk.sv]
// Sequence: a load writes a corner; a ring read fetches an entry and its vertex;
//   a walk runs a mark-clearing sweep, its start states, walk steps and closing states.
// Throughput: one request at a time; the next is taken as the engine goes idle
//   while the output register may still hold the previous result.
// Reset (sync, rst_n low): face_count 1024, vertex_count 512, ring, stack and tally
//   counts and covered flag zero, output empty; corner table undefined until loaded.
module mesh_vertex_ring_walk #(
  parameter int MAX_FACES    = mvrw_pkg::MAX_FACES_DEF,
  parameter int MAX_VERTICES = mvrw_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mvrw_in_if.sink                     in_chan,
  mvrw_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mvrw_pkg::ADDR_W-1:0] paddr,
  input  logic [mvrw_pkg::DATA_W-1:0] pwdata,
  output logic [mvrw_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  mvrw_pkg::cfg_t    cfg;
  mvrw_pkg::item_t   item;
  mvrw_pkg::result_t res;
  mvrw_pkg::result_t out_res_r;
  logic              eng_idle;
  logic              res_valid;
  logic              res_ready;
  logic              res_take;
  logic              out_valid_r, out_valid_nxt;

  // register file
  mvrw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // request in: the engine takes one whenever it is idle
  assign item.opcode          = in_chan.opcode;
  assign item.index           = in_chan.index;
  assign item.corner_vertex   = in_chan.corner_vertex;
  assign item.corner_opposite = in_chan.corner_opposite;
  assign in_chan.ready        = eng_idle;

  mvrw_engine #(
    .MAX_FACES    (MAX_FACES),
    .MAX_VERTICES (MAX_VERTICES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (in_chan.valid),
    .item       (item),
    .idle       (eng_idle),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register decouples the engine from a stalled consumer
  assign res_ready     = !out_valid_r || out_chan.ready;
  assign res_take      = res_valid && res_ready;
  assign out_valid_nxt = res_take || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.ring_corner      = out_res_r.ring_corner;
  assign out_chan.ring_vertex      = out_res_r.ring_vertex;
  assign out_chan.ring_length      = out_res_r.ring_length;
  assign out_chan.marked_vertices  = out_res_r.marked_vertices;
  assign out_chan.marked_triangles = out_res_r.marked_triangles;
  assign out_chan.all_covered      = out_res_r.all_covered;
  assign out_chan.status           = out_res_r.status;

endmodule
